@@ rtl/core/gpl_pkg.sv @@
package gpl_pkg;

    localparam int PIXEL_BITS_DEF = 8;

    // Fixed-point formats of the datapath.
    localparam int LOG_FRAC   = 24;
    localparam int Q          = 30;
    localparam int GAMMA_W    = 16;
    localparam int GAMMA_FRAC = 12;
    localparam logic [GAMMA_W-1:0] GAMMA_RESET = 16'd4096;

    // The first HEAD_BITS fraction bits of the exponent go through a table,
    // the remaining TAIL_BITS through one multiply stage each.
    localparam int HEAD_BITS = 8;
    localparam int TAIL_BITS = LOG_FRAC - HEAD_BITS;
    localparam int ACC_W     = Q + 1;
    localparam int C_W       = Q;

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bit_w;
        begin
            v     = v_in;
            res   = 64'd0;
            bit_w = 64'd1 << 62;
            for (int k = 0; k < 32; k++)
            begin
                if (v >= res + bit_w)
                begin
                    v   = v - (res + bit_w);
                    res = (res >> 1) + bit_w;
                end
                else
                begin
                    res = res >> 1;
                end
                bit_w = bit_w >> 2;
            end
            return res;
        end
    endfunction

    // log2 in Q24 by normalization and repeated squaring.
    function automatic logic [63:0] log2_q24(input logic [63:0] x);
        logic [63:0] m;
        logic [63:0] res;
        int          n;
        begin
            n = 0;
            for (int b = 1; b < 32; b++)
            begin
                if ((x >> b) != 64'd0)
                    n = b;
            end
            m   = x << (Q - n);
            res = 64'(n) << LOG_FRAC;
            for (int i = LOG_FRAC - 1; i >= 0; i--)
            begin
                m = (m * m) >> Q;
                if (m >= (64'd2 << Q))
                begin
                    m      = m >> 1;
                    res[i] = 1'b1;
                end
            end
            return res;
        end
    endfunction

    // Distance in octaves from level x up to the top level, in Q24.
    function automatic logic [63:0] log_dist(input logic [63:0] x, input logic [63:0] top);
        logic [63:0] lm;
        logic [63:0] lr;
        begin
            lm = log2_q24(top);
            lr = log2_q24(x);
            return (lm > lr) ? (lm - lr) : 64'd0;
        end
    endfunction

    // 2^(-2^-j) in Q30.
    function automatic logic [63:0] root_const(input int j);
        logic [63:0] c;
        begin
            c = 64'd1 << (Q - 1);
            for (int k = 1; k <= j; k++)
                c = isqrt64(c << Q);
            return c;
        end
    endfunction

    // Partial 2^-f in Q30 for the top HEAD_BITS fraction bits, multiplied in
    // the same order and with the same truncation as the tail stages.
    function automatic logic [63:0] exp_head(input logic [HEAD_BITS-1:0] idx);
        logic [63:0] acc;
        logic [63:0] c;
        begin
            acc = 64'd1 << Q;
            c   = 64'd1 << (Q - 1);
            for (int j = 1; j <= HEAD_BITS; j++)
            begin
                c = isqrt64(c << Q);
                if (idx[HEAD_BITS-j])
                    acc = (acc * c) >> Q;
            end
            return acc;
        end
    endfunction

endpackage

@@ rtl/core/gamma_power_law_pixel.sv @@
// Power-law (gamma) transform of one grey pixel: pixel_out = floor(M*(r/M)^gamma)
// with M = 2^PIXEL_BITS - 1, gamma taken from the Q4.12 register written through
// the cfg port (reset value 1.0). The block accepts one pixel per clock while
// in_stall is low. The pipeline looks up the log distance to the top level in a
// ROM of 2^PIXEL_BITS entries, multiplies it by gamma, reads the first eight
// exponent fraction bits from a 256-entry table and then spends one multiply
// stage on each of the sixteen remaining fraction bits before the final scale.
// Each stage holds its item only while the stage after it is full and stalled,
// so bubbles close up and a result waiting at the output does not stop new
// pixels from entering while any stage is empty. Gamma should only be written
// while no pixel is in flight.
module gamma_power_law_pixel #(
    parameter int PIXEL_BITS = gpl_pkg::PIXEL_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [PIXEL_BITS-1:0]         pixel_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [PIXEL_BITS-1:0]         pixel_out,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [gpl_pkg::GAMMA_W-1:0]   cfg_data
);

    localparam int PIX_CNT = 1 << PIXEL_BITS;
    localparam logic [PIXEL_BITS-1:0] PIX_MAX = {PIXEL_BITS{1'b1}};
    localparam int DW    = $clog2(PIXEL_BITS) + gpl_pkg::LOG_FRAC;
    localparam int DGW   = DW + gpl_pkg::GAMMA_W;
    localparam int EW    = DGW - gpl_pkg::GAMMA_FRAC;
    localparam int IPW   = EW - gpl_pkg::LOG_FRAC;
    localparam int IP_W  = $clog2(PIXEL_BITS + 1);
    localparam int NTAIL = gpl_pkg::TAIL_BITS;
    localparam int NST   = NTAIL + 5;
    localparam int PW    = PIXEL_BITS + gpl_pkg::ACC_W;
    localparam int MW    = gpl_pkg::ACC_W + gpl_pkg::C_W;
    localparam int ST_X0 = 2;
    localparam int ST_P  = ST_X0 + NTAIL + 1;
    localparam int ST_O  = ST_P + 1;

    typedef struct packed {
        logic                             kill;
        logic [IP_W-1:0]                  ip;
        logic [gpl_pkg::TAIL_BITS-1:0]    frac;
        logic [gpl_pkg::ACC_W-1:0]        acc;
    } exp_slot_t;

    // Constant tables.
    logic [DW-1:0]             dist_rom [PIX_CNT];
    logic [gpl_pkg::ACC_W-1:0] head_tab [1 << gpl_pkg::HEAD_BITS];
    logic [gpl_pkg::C_W-1:0]   root_c   [NTAIL];

    for (genvar gi = 0; gi < PIX_CNT; gi++)
    begin : g_dist
        localparam logic [63:0] DV = gpl_pkg::log_dist(64'(gi), 64'(PIX_CNT - 1));
        assign dist_rom[gi] = DV[DW-1:0];
    end

    for (genvar gh = 0; gh < (1 << gpl_pkg::HEAD_BITS); gh++)
    begin : g_head
        localparam logic [63:0] HV =
            gpl_pkg::exp_head(gpl_pkg::HEAD_BITS'(gh));
        assign head_tab[gh] = HV[gpl_pkg::ACC_W-1:0];
    end

    for (genvar gr = 0; gr < NTAIL; gr++)
    begin : g_root
        localparam logic [63:0] RV =
            gpl_pkg::root_const(gpl_pkg::HEAD_BITS + 1 + gr);
        assign root_c[gr] = RV[gpl_pkg::C_W-1:0];
    end

    // Flow control: a stage advances unless it and every stage after it
    // are full and the output is stalled.
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] en;

    for (genvar ge = 0; ge < NST; ge++)
    begin : g_en
        assign en[ge] = !(&vld_reg[NST-1:ge]) || !out_stall;
    end

    assign in_stall  = !en[0];
    assign out_valid = vld_reg[NST-1];
    assign cfg_ready = 1'b1;

    logic [gpl_pkg::GAMMA_W-1:0] gamma_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            gamma_reg <= gpl_pkg::GAMMA_RESET;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                gamma_reg <= cfg_data;
            if (en[0])
                vld_reg[0] <= in_valid;
            for (int k = 1; k < NST; k++)
            begin
                if (en[k])
                    vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // Stage 0: log distance lookup.
    logic          zero0_reg;
    logic [DW-1:0] d0_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            zero0_reg <= (pixel_in == '0);
            d0_reg    <= dist_rom[pixel_in];
        end
    end

    // Stage 1: scale by gamma.
    logic           zero1_reg;
    logic [EW-1:0]  e1_reg;
    logic [DGW-1:0] dg_next;

    assign dg_next = DGW'(d0_reg) * DGW'(gamma_reg);

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            zero1_reg <= zero0_reg;
            e1_reg    <= dg_next[gpl_pkg::GAMMA_FRAC +: EW];
        end
    end

    // Stage 2: split into whole octaves and fraction, table for the head bits.
    // Stages 3 and on: one conditional multiply per remaining fraction bit.
    exp_slot_t      xs_reg  [NTAIL+1];
    exp_slot_t      xs_next [NTAIL+1];
    logic [IPW-1:0] ip_full;

    assign ip_full = e1_reg[EW-1:gpl_pkg::LOG_FRAC];

    assign xs_next[0] = '{
        kill: zero1_reg || (ip_full > IPW'(PIXEL_BITS)),
        ip:   ip_full[IP_W-1:0],
        frac: e1_reg[gpl_pkg::TAIL_BITS-1:0],
        acc:  head_tab[e1_reg[gpl_pkg::LOG_FRAC-1 -: gpl_pkg::HEAD_BITS]]
    };

    for (genvar gk = 0; gk < NTAIL; gk++)
    begin : g_tail
        logic [MW-1:0] tail_mul;

        assign tail_mul = MW'(xs_reg[gk].acc) * MW'(root_c[gk]);
        assign xs_next[gk+1] = '{
            kill: xs_reg[gk].kill,
            ip:   xs_reg[gk].ip,
            frac: xs_reg[gk].frac,
            acc:  xs_reg[gk].frac[NTAIL-1-gk] ? tail_mul[gpl_pkg::Q +: gpl_pkg::ACC_W]
                                               : xs_reg[gk].acc
        };
    end

    for (genvar gx = 0; gx <= NTAIL; gx++)
    begin : g_xs
        always_ff @(posedge clk)
        begin
            if (en[ST_X0 + gx])
                xs_reg[gx] <= xs_next[gx];
        end
    end

    // Scale by the top level, then shift out the whole octaves and clamp.
    logic            kill_p_reg;
    logic [IP_W-1:0] ip_p_reg;
    logic [PW-1:0]   prod_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_P])
        begin
            kill_p_reg <= xs_reg[NTAIL].kill;
            ip_p_reg   <= xs_reg[NTAIL].ip;
            prod_reg   <= PW'(PIX_MAX) * PW'(xs_reg[NTAIL].acc);
        end
    end

    logic [PW-1:0]         prod_sh;
    logic [PIXEL_BITS:0]   v_full;
    logic [PIXEL_BITS-1:0] pixel_out_reg;
    logic [PIXEL_BITS-1:0] pixel_out_next;

    assign prod_sh = prod_reg >> ip_p_reg;
    assign v_full  = prod_sh[gpl_pkg::Q +: PIXEL_BITS + 1];

    always_comb
    begin
        if (kill_p_reg)
            pixel_out_next = '0;
        else if (v_full > {1'b0, PIX_MAX})
            pixel_out_next = PIX_MAX;
        else
            pixel_out_next = v_full[PIXEL_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_O])
            pixel_out_reg <= pixel_out_next;
    end

    assign pixel_out = pixel_out_reg;

endmodule

@@ rtl/core/gpl_checker.sv @@
module gpl_checker #(
    parameter int PIXEL_BITS = gpl_pkg::PIXEL_BITS_DEF
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [PIXEL_BITS-1:0] pixel_out
);

    // Nothing leaves the pipeline while reset holds it empty.
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("out_valid high during reset");

    // A stalled result stays in place with its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pixel_out))
        else $error("stalled result changed or was dropped");

    // The input side backs up only when the pipeline is full behind a
    // stalled output; any bubble must let a new transfer in.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output is free");

endmodule

bind gamma_power_law_pixel gpl_checker #(.PIXEL_BITS(PIXEL_BITS)) u_gpl_checker (.*);

@@ tb/tb_top.sv @@
module tb_top;

    localparam int PB      = gpl_pkg::PIXEL_BITS_DEF;
    localparam int GW      = gpl_pkg::GAMMA_W;
    localparam int LOGF    = 24;
    localparam int QF      = 30;
    localparam logic [63:0] TOP_LEVEL = (64'd1 << PB) - 64'd1;

    // Named gamma settings in Q4.12.
    localparam logic [GW-1:0] GAMMA_MIN     = 16'd1;
    localparam logic [GW-1:0] GAMMA_MAX     = 16'hFFFF;
    localparam logic [GW-1:0] GAMMA_DISPLAY = 16'd9011;   // about 2.2
    localparam logic [GW-1:0] GAMMA_INVERSE = 16'd1862;   // about 1/2.2

    localparam logic [PB-1:0] DIR_UNITY [14] =
        '{8'd0, 8'd255, 8'd1, 8'd2, 8'd3, 8'd127, 8'd128, 8'd129,
          8'd254, 8'd85, 8'd170, 8'd15, 8'd16, 8'd240};
    localparam logic [PB-1:0] DIR_EXTREME [6] =
        '{8'd0, 8'd1, 8'd255, 8'd254, 8'd128, 8'd2};

    class gamma_scoreboard;
        logic [GW-1:0] gamma_q12;
        logic [PB-1:0] sent_px[$];
        logic [PB-1:0] expected_px[$];
        int unsigned   n_checked;
        int unsigned   n_mismatch;
        int unsigned   n_unexpected;

        function void set_gamma(input logic [GW-1:0] g);
            gamma_q12 = g;
        endfunction

        function logic [63:0] sqrt_floor(input logic [63:0] v_in);
            logic [63:0] v;
            logic [63:0] root;
            logic [63:0] probe;
            v     = v_in;
            root  = 64'd0;
            probe = 64'd1 << 62;
            while (probe > v)
                probe = probe >> 2;
            while (probe != 64'd0)
            begin
                if (v >= root + probe)
                begin
                    v    = v - (root + probe);
                    root = (root >> 1) + probe;
                end
                else
                    root = root >> 1;
                probe = probe >> 2;
            end
            return root;
        endfunction

        // log2 of x with 24 fraction bits: normalize, then square repeatedly.
        function logic [63:0] log2_fix(input logic [63:0] x);
            int          msb;
            logic [63:0] mant;
            logic [63:0] acc;
            msb = 0;
            while (msb < 31 && (x >> (msb + 1)) != 64'd0)
                msb++;
            mant = x << (QF - msb);
            acc  = 64'(msb) << LOGF;
            for (int i = LOGF - 1; i >= 0; i--)
            begin
                mant = (mant * mant) >> QF;
                if (mant >= (64'd2 << QF))
                begin
                    mant   = mant >> 1;
                    acc[i] = 1'b1;
                end
            end
            return acc;
        endfunction

        // 2^(-f) in Q30 for a fraction f with 24 bits.
        function logic [63:0] pow2_neg(input logic [63:0] frac);
            logic [63:0] acc;
            logic [63:0] root;
            acc  = 64'd1 << QF;
            root = 64'd1 << (QF - 1);
            for (int j = 1; j <= LOGF; j++)
            begin
                root = sqrt_floor(root << QF);
                if (frac[LOGF - j])
                    acc = (acc * root) >> QF;
            end
            return acc;
        endfunction

        function logic [PB-1:0] gamma_level(input logic [PB-1:0] r);
            logic [63:0] l_in;
            logic [63:0] l_top;
            logic [63:0] log_gap;
            logic [63:0] expo;
            logic [63:0] whole;
            logic [63:0] level;
            if (r == '0)
                return '0;
            l_in    = log2_fix(64'(r));
            l_top   = log2_fix(TOP_LEVEL);
            log_gap = (l_top > l_in) ? (l_top - l_in) : 64'd0;
            expo    = (log_gap * 64'(gamma_q12)) >> gpl_pkg::GAMMA_FRAC;
            whole   = expo >> LOGF;
            // Past PIXEL_BITS whole octaves the result is below one level.
            if (whole > 64'(PB))
                return '0;
            level = (TOP_LEVEL * pow2_neg(expo & ((64'd1 << LOGF) - 64'd1)))
                    >> (QF + whole);
            if (level > TOP_LEVEL)
                level = TOP_LEVEL;
            return level[PB-1:0];
        endfunction

        function void note_pixel(input logic [PB-1:0] r);
            sent_px.push_back(r);
            expected_px.push_back(gamma_level(r));
        endfunction

        function void check_pixel(input logic [PB-1:0] got);
            logic [PB-1:0] r;
            logic [PB-1:0] want;
            if (expected_px.size() == 0)
            begin
                n_unexpected++;
                if (n_mismatch + n_unexpected <= 10)
                    $display("ERROR: result %0d arrived with no pixel outstanding", got);
                return;
            end
            r    = sent_px.pop_front();
            want = expected_px.pop_front();
            n_checked++;
            if (got !== want)
            begin
                n_mismatch++;
                if (n_mismatch + n_unexpected <= 10)
                    $display("ERROR: pixel_in %0d gamma_q12 %0d: expected %0d, got %0d",
                             r, gamma_q12, want, got);
            end
        endfunction

        function int pending();
            return expected_px.size();
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_stall;
    logic [PB-1:0] pixel_in;
    logic          out_valid;
    logic          out_stall;
    logic [PB-1:0] pixel_out;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [GW-1:0] cfg_data;

    gamma_scoreboard sb = new;
    int unsigned     n_sent;
    int unsigned     n_settings;

    gamma_power_law_pixel #(.PIXEL_BITS(PB)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pixel_in  (pixel_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pixel_out (pixel_out),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("Timeout with %0d pixels still outstanding", sb.pending());
        $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_pixel(pixel_out);
    end

    // Output backpressure: stretches with no stall, random stalls at a rate of one in
    // four or one in two, and occasional long holds.
    initial
    begin
        int  mode;
        int  hold;
        bit  stall_next;
        out_stall = 1'b0;
        hold      = 0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(20, 200))
            begin
                @(negedge clk);
                stall_next = 1'b0;
                if (hold > 0)
                begin
                    stall_next = 1'b1;
                    hold--;
                end
                else if (mode == 1)
                    stall_next = ($urandom_range(0, 3) == 0);
                else if (mode == 2)
                    stall_next = ($urandom_range(0, 1) == 0);
                else if (mode == 3 && $urandom_range(0, 24) == 0)
                    hold = $urandom_range(8, 40);
                out_stall <= stall_next;
            end
        end
    end

    function automatic int gap_len(input bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic [PB-1:0] pick_pixel();
        int k;
        if ($urandom_range(0, 9) < 7)
            return PB'($urandom_range(0, int'(TOP_LEVEL)));
        k = $urandom_range(0, PB - 1);
        case ($urandom_range(0, 3))
            0: return PB'(1 << k);
            1: return PB'((1 << k) - 1);
            2: return PB'(TOP_LEVEL - k);
            default: return PB'(k);
        endcase
    endfunction

    task automatic send_pixel(input logic [PB-1:0] p);
        @(negedge clk);
        in_valid <= 1'b1;
        pixel_in <= p;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_pixel(p);
        n_sent++;
    endtask

    task automatic idle_input(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            pixel_in <= PB'($urandom);
        end
    endtask

    task automatic drain();
        idle_input(1);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_gamma(input logic [GW-1:0] g);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= g;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_gamma(g);
        n_settings++;
        @(negedge clk);
        cfg_valid <= 1'b0;
        cfg_data  <= GW'($urandom);
    endtask

    task automatic random_phase(input logic [GW-1:0] g, input int count);
        bit quiet;
        quiet = 1'b0;
        write_gamma(g);
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
                quiet = ($urandom_range(0, 2) == 0);
            send_pixel(pick_pixel());
            idle_input(gap_len(quiet));
        end
        drain();
    endtask

    initial
    begin
        int unsigned fails;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        pixel_in   = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        n_sent     = 0;
        n_settings = 1;
        sb.set_gamma(gpl_pkg::GAMMA_RESET);
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: gamma 1.0 from reset, then the smallest and largest gamma.
        foreach (DIR_UNITY[i])
        begin
            send_pixel(DIR_UNITY[i]);
            idle_input(gap_len(1'b0));
        end
        drain();
        write_gamma(GAMMA_MIN);
        for (int i = 0; i < 5; i++)
            send_pixel(DIR_EXTREME[i]);
        drain();
        write_gamma(GAMMA_MAX);
        foreach (DIR_EXTREME[i])
            send_pixel(DIR_EXTREME[i]);
        drain();

        random_phase(GAMMA_DISPLAY, 200);
        random_phase(GAMMA_INVERSE, 200);
        random_phase(GAMMA_MIN, 200);
        random_phase(GAMMA_MAX, 200);
        random_phase(GW'($urandom_range(400, 16384)), 200);
        random_phase(GW'($urandom_range(1, 65535)), 200);
        random_phase(GW'($urandom_range(400, 16384)), 200);
        random_phase(gpl_pkg::GAMMA_RESET, 200);

        // Room for any stray result the block might still produce.
        repeat (40) @(posedge clk);

        fails = sb.n_mismatch + sb.n_unexpected + sb.pending();
        $display("Run covered %0d pixels over %0d gamma settings, including 1 and 65535,",
                 n_sent, n_settings);
        $display("with %0d results compared, %0d wrong, %0d unexpected, %0d missing.",
                 sb.n_checked, sb.n_mismatch, sb.n_unexpected, sb.pending());
        if (fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
